@@ src/wir_pkg.sv @@
// Shared constants, codes and types of the weighted impedance residual unit.
`timescale 1ns / 1ps

package wir_pkg;

  // Weighting mode codes
  localparam logic [2:0] MODE_UNITY     = 3'd0;
  localparam logic [2:0] MODE_MOD_MEAS  = 3'd1;
  localparam logic [2:0] MODE_PROP_MEAS = 3'd2;
  localparam logic [2:0] MODE_MOD_FIT   = 3'd3;
  localparam logic [2:0] MODE_PROP_FIT  = 3'd4;
  localparam logic [2:0] MODE_MOD_AUTO  = 3'd5;
  localparam logic [2:0] MODE_PROP_AUTO = 3'd6;

  // Register indexes (paddr[2]) and reset values
  localparam logic       REG_MODE    = 1'b0;
  localparam logic       REG_FLOOR   = 1'b1;
  localparam logic [2:0] MODE_RESET  = MODE_MOD_AUTO;
  localparam logic [15:0] FLOOR_RESET = 16'd1;

  // Sweep counter saturates here
  localparam logic [1:0] SWEEP_MAX = 2'd2;
  localparam logic [1:0] SWEEP_ONE = 2'd1;

  // Q32.32 clip limits
  localparam logic [63:0] LIM_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM_NEG = 64'h8000_0000_0000_0000;

  // Quotient bits produced by one divider lane, one per cycle
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [2:0]  weighting_mode;
    logic [15:0] square_floor;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic               unity;
    logic signed [32:0] d;
    logic [63:0]        den;
  } lane_req_t;

  typedef struct packed {
    logic        busy;
    logic        sat;
    logic [63:0] value;
  } lane_rsp_t;

endpackage

@@ src/wir_stream_if.sv @@
// Stream interfaces for frequency points in and weighted residuals out.
`timescale 1ns / 1ps

interface wir_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] meas_real;
  logic signed [31:0] meas_imag;
  logic signed [31:0] fit_real;
  logic signed [31:0] fit_imag;
  logic               new_evaluation;

  modport source (output valid, meas_real, meas_imag, fit_real, fit_imag, new_evaluation,
                  input ready);
  modport sink (input valid, meas_real, meas_imag, fit_real, fit_imag, new_evaluation,
                output ready);
endinterface

interface wir_resid_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] resid_real;
  logic signed [63:0] resid_imag;
  logic               saturated;

  modport source (output valid, resid_real, resid_imag, saturated, input ready);
  modport sink (input valid, resid_real, resid_imag, saturated, output ready);
endinterface

@@ src/wir_cfg.sv @@
// APB register block: weighting mode and square floor.
`timescale 1ns / 1ps

module wir_cfg import wir_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg,
  output logic        mode_write
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // write side; low address bits are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.weighting_mode <= MODE_RESET;
      cfg.square_floor   <= FLOOR_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_MODE:  cfg.weighting_mode <= pwdata[2:0];
        REG_FLOOR: cfg.square_floor   <= pwdata[15:0];
      endcase
    end
  end

  // a mode write restarts sweep counting
  assign mode_write = wr_en && (paddr[2] == REG_MODE);

  // read mux
  always_comb begin
    unique case (paddr[2])
      REG_MODE:  prdata = {29'b0, cfg.weighting_mode};
      REG_FLOOR: prdata = {16'b0, cfg.square_floor};
    endcase
  end

endmodule

@@ src/wir_lane.sv @@
// One residual lane: bit-serial restoring divider with clip and floor handling.
`timescale 1ns / 1ps

module wir_lane import wir_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  lane_req_t   req,
  input  logic [15:0] square_floor,
  output lane_rsp_t   rsp
);

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_RUN  = 2'd1;
  localparam logic [1:0] L_FIX  = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic [63:0]      den;
  logic [63:0]      rem;
  logic [63:0]      quo;
  logic [63:0]      value;
  logic             sat;

  logic [32:0] mag;
  logic        small_sq;
  logic        over;
  logic [63:0] lim_in;
  logic [64:0] rs;
  logic [65:0] diff;
  logic        ge;
  logic        q_sat;
  logic [63:0] lim_q;

  // start-time checks on the request
  always_comb begin
    mag      = req.d[32] ? 33'(-req.d) : 33'(req.d);
    small_sq = (req.den == 64'd0) || (req.den < {48'b0, square_floor});
    // quotient would need more than 64 bits
    over     = (req.den[63:17] == 47'd0) && (mag >= {req.den[16:0], 16'b0});
    lim_in   = req.d[32] ? LIM_NEG : LIM_POS;
  end

  // one quotient bit: dividend bits leave the top of quo, quotient bits enter below
  always_comb begin
    rs   = {rem, quo[63]};
    diff = {1'b0, rs} - {2'b0, den};
    ge   = !diff[65];
  end

  // final clip against the sign-dependent limit
  always_comb begin
    q_sat = quo[63] && (!neg || (quo[62:0] != 63'd0));
    lim_q = neg ? LIM_NEG : LIM_POS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      unique case (state)
        L_IDLE: begin
          if (req.start && !req.unity && !small_sq && !over) begin
            state <= L_RUN;
          end
        end
        L_RUN: begin
          if (cnt == '0) begin
            state <= L_FIX;
          end
        end
        L_FIX: begin
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      L_IDLE: begin
        if (req.start) begin
          neg <= req.d[32];
          den <= req.den;
          cnt <= CNT_W'(DIV_STEPS - 1);
          rem <= 64'(mag[32:16]);
          quo <= {mag[15:0], 48'b0};
          if (req.unity) begin
            value <= {{15{req.d[32]}}, req.d, 16'b0};
            sat   <= 1'b0;
          end else if (small_sq) begin
            value <= (mag == 33'd0) ? 64'd0 : lim_in;
            sat   <= (mag != 33'd0);
          end else if (over) begin
            value <= lim_in;
            sat   <= 1'b1;
          end
        end
      end
      L_RUN: begin
        rem <= ge ? diff[63:0] : rs[63:0];
        quo <= {quo[62:0], ge};
        cnt <= cnt - 1'b1;
      end
      L_FIX: begin
        sat   <= q_sat;
        value <= q_sat ? lim_q : (neg ? (64'd0 - quo) : quo);
      end
      default: ;
    endcase
  end

  assign rsp.busy  = (state != L_IDLE);
  assign rsp.sat   = sat;
  assign rsp.value = value;

endmodule

@@ src/weighted_impedance_residual_unit.sv @@
// Top level: point intake, weighting selection, squares, two divider lanes, result register.
// A point passes ST_SQUARE and ST_LAUNCH, then waits in ST_WAIT while the lanes divide; the result
//   is registered once both lanes are idle and the output register is free (unity weight, or both
//   parts taking maximum weight or clipping before dividing, skip the 64-step bit-serial divider in each lane).
// The next point is taken only once the result is in the output register, so points do not overlap.
// Reset: rst is synchronous; mode returns to 5, floor to 1, sweep count to 0, channels empty.
`timescale 1ns / 1ps

module weighted_impedance_residual_unit import wir_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  wir_point_if.sink    point,
  wir_resid_if.source  resid
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SQUARE = 2'd1;
  localparam logic [1:0] ST_LAUNCH = 2'd2;
  localparam logic [1:0] ST_WAIT   = 2'd3;

  cfg_t        cfg;
  logic        mode_write;
  logic [1:0]  state;
  logic [1:0]  sweep_count;
  logic [1:0]  sweep_count_next;

  logic signed [32:0] dr;
  logic signed [32:0] di;
  logic [31:0] ar;
  logic [31:0] ai;
  logic        unity;
  logic        modulus;
  logic [63:0] sqr;
  logic [63:0] sqi;

  logic        resid_valid;
  logic [63:0] resid_real;
  logic [63:0] resid_imag;
  logic        resid_sat;

  logic        accept;
  logic [2:0]  eff_mode;
  logic        use_meas;
  logic        modulus_d;
  logic        unity_d;
  logic signed [31:0] wr;
  logic signed [31:0] wi;
  logic [63:0] sq_sum;
  logic        out_free;
  logic        lanes_done;

  lane_req_t   req_r;
  lane_req_t   req_i;
  lane_rsp_t   rsp_r;
  lane_rsp_t   rsp_i;

  wir_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cfg        (cfg),
    .mode_write (mode_write)
  );

  assign point.ready = (state == ST_IDLE);
  assign accept      = point.valid && point.ready;

  // sweep count as seen by the point being accepted
  always_comb begin
    sweep_count_next = sweep_count;
    if (point.new_evaluation && (sweep_count != SWEEP_MAX)) begin
      sweep_count_next = sweep_count + 1'b1;
    end
  end

  // resolve auto modes, then decode
  always_comb begin
    eff_mode = cfg.weighting_mode;
    if (cfg.weighting_mode == MODE_MOD_AUTO) begin
      eff_mode = (sweep_count_next == SWEEP_ONE) ? MODE_MOD_MEAS : MODE_MOD_FIT;
    end else if (cfg.weighting_mode == MODE_PROP_AUTO) begin
      eff_mode = (sweep_count_next == SWEEP_ONE) ? MODE_PROP_MEAS : MODE_PROP_FIT;
    end
    use_meas  = (eff_mode == MODE_MOD_MEAS) || (eff_mode == MODE_PROP_MEAS);
    modulus_d = (eff_mode == MODE_MOD_MEAS) || (eff_mode == MODE_MOD_FIT);
    unity_d   = !(modulus_d || (eff_mode == MODE_PROP_MEAS) || (eff_mode == MODE_PROP_FIT));
    wr        = use_meas ? point.meas_real : point.fit_real;
    wi        = use_meas ? point.meas_imag : point.fit_imag;
  end

  // sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_count <= 2'd0;
    end else if (mode_write) begin
      sweep_count <= 2'd0;
    end else if (accept) begin
      sweep_count <= sweep_count_next;
    end
  end

  // point capture and squares
  always_ff @(posedge clk) begin
    if (accept) begin
      dr      <= {point.fit_real[31], point.fit_real} - {point.meas_real[31], point.meas_real};
      di      <= {point.fit_imag[31], point.fit_imag} - {point.meas_imag[31], point.meas_imag};
      ar      <= wr[31] ? (32'd0 - wr) : wr;
      ai      <= wi[31] ? (32'd0 - wi) : wi;
      unity   <= unity_d;
      modulus <= modulus_d;
    end
    if (state == ST_SQUARE) begin
      sqr <= ar * ar;
      sqi <= ai * ai;
    end
  end

  // lane requests
  always_comb begin
    sq_sum      = sqr + sqi;
    req_r.start = (state == ST_LAUNCH);
    req_r.unity = unity;
    req_r.d     = dr;
    req_r.den   = modulus ? sq_sum : sqr;
    req_i.start = (state == ST_LAUNCH);
    req_i.unity = unity;
    req_i.d     = di;
    req_i.den   = modulus ? sq_sum : sqi;
  end

  wir_lane u_lane_real (
    .clk          (clk),
    .rst          (rst),
    .req          (req_r),
    .square_floor (cfg.square_floor),
    .rsp          (rsp_r)
  );

  wir_lane u_lane_imag (
    .clk          (clk),
    .rst          (rst),
    .req          (req_i),
    .square_floor (cfg.square_floor),
    .rsp          (rsp_i)
  );

  assign out_free   = !resid_valid || resid.ready;
  assign lanes_done = !rsp_r.busy && !rsp_i.busy;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE:   if (accept) state <= ST_SQUARE;
        ST_SQUARE: state <= ST_LAUNCH;
        ST_LAUNCH: state <= ST_WAIT;
        ST_WAIT:   if (lanes_done && out_free) state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      resid_valid <= 1'b0;
    end else if ((state == ST_WAIT) && lanes_done && out_free) begin
      resid_valid <= 1'b1;
    end else if (resid.ready) begin
      resid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_WAIT) && lanes_done && out_free) begin
      resid_real <= rsp_r.value;
      resid_imag <= rsp_i.value;
      resid_sat  <= rsp_r.sat || rsp_i.sat;
    end
  end

  assign resid.valid      = resid_valid;
  assign resid.resid_real = resid_real;
  assign resid.resid_imag = resid_imag;
  assign resid.saturated  = resid_sat;

  // a new point only enters with both lanes idle
  a_ready_lanes_idle: assert property (@(posedge clk) disable iff (rst)
    point.ready |-> (!rsp_r.busy && !rsp_i.busy))
    else $error("point taken while a divider lane is busy");

  // sweep counter saturates at two
  a_sweep_range: assert property (@(posedge clk) disable iff (rst)
    sweep_count <= SWEEP_MAX)
    else $error("sweep count beyond saturation");

  // a saturated result carries a clip limit in at least one part
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (resid_valid && resid_sat) |->
      ((resid_real == LIM_POS) || (resid_real == LIM_NEG) ||
       (resid_imag == LIM_POS) || (resid_imag == LIM_NEG)))
    else $error("saturated flag without a clipped residual");

endmodule

@@ bench/wir_residual_checker.sv @@
// Passive checker: tracks register writes, predicts each weighted residual beat and compares.
`timescale 1ns / 1ps

module wir_residual_checker import wir_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  wir_point_if        point,
  wir_resid_if        resid,
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    logic [63:0] re;
    logic [63:0] im;
    logic        sat;
  } residual_t;

  residual_t   expected_resid_q[$];
  logic [2:0]  mode_r;
  logic [15:0] floor_r;
  logic [1:0]  sweep_r;

  // One weighted part: d * 2^48 / square, truncated toward zero, clipped; d * 2^16 at unity weight
  function automatic logic [63:0] weighted_part(input logic signed [32:0] d,
                                                input logic unity_w,
                                                input logic [63:0] sq,
                                                output logic clipped);
    logic signed [63:0] dx;
    logic [63:0]        mag;
    logic [63:0]        lim;
    logic [127:0]       quo;
    logic               neg;
    clipped = 1'b0;
    dx  = {{31{d[32]}}, d};
    neg = d[32];
    if (unity_w) return dx << 16;
    mag = neg ? (64'd0 - dx) : dx;
    // square below the floor, or zero: maximum weight
    if (sq == 64'd0 || sq < {48'd0, floor_r}) begin
      if (mag == 64'd0) return 64'd0;
      clipped = 1'b1;
      return neg ? LIM_NEG : LIM_POS;
    end
    lim = neg ? LIM_NEG : LIM_POS;
    quo = {64'd0, mag} << 48;
    quo = quo / {64'd0, sq};
    if (quo > {64'd0, lim}) begin
      clipped = 1'b1;
      quo = {64'd0, lim};
    end
    return neg ? (64'd0 - quo[63:0]) : quo[63:0];
  endfunction

  // Full residual beat from one point, with sweep count already advanced
  function automatic residual_t predict_residual(input logic [31:0] mr, input logic [31:0] mi,
                                                 input logic [31:0] fr, input logic [31:0] fi);
    residual_t          r;
    logic [2:0]         eff;
    logic               use_meas, modulus, unity_w, sat_re, sat_im;
    logic signed [32:0] dr, di;
    logic [31:0]        wr, wi, ar, ai;
    logic [63:0]        sqr, sqi;
    eff = mode_r;
    if (mode_r == MODE_MOD_AUTO)
      eff = (sweep_r == SWEEP_ONE) ? MODE_MOD_MEAS : MODE_MOD_FIT;
    else if (mode_r == MODE_PROP_AUTO)
      eff = (sweep_r == SWEEP_ONE) ? MODE_PROP_MEAS : MODE_PROP_FIT;
    use_meas = (eff == MODE_MOD_MEAS) || (eff == MODE_PROP_MEAS);
    modulus  = (eff == MODE_MOD_MEAS) || (eff == MODE_MOD_FIT);
    unity_w  = !(modulus || eff == MODE_PROP_MEAS || eff == MODE_PROP_FIT);
    dr = {fr[31], fr} - {mr[31], mr};
    di = {fi[31], fi} - {mi[31], mi};
    wr = use_meas ? mr : fr;
    wi = use_meas ? mi : fi;
    ar = wr[31] ? (~wr + 32'd1) : wr;
    ai = wi[31] ? (~wi + 32'd1) : wi;
    sqr = {32'd0, ar} * {32'd0, ar};
    sqi = {32'd0, ai} * {32'd0, ai};
    if (modulus) begin
      sqr = sqr + sqi;
      sqi = sqr;
    end
    r.re  = weighted_part(dr, unity_w, sqr, sat_re);
    r.im  = weighted_part(di, unity_w, sqi, sat_im);
    r.sat = sat_re | sat_im;
    return r;
  endfunction

  // Register shadow, sweep tracking, expectation store and comparison
  always @(posedge clk) begin : track
    residual_t want, got;
    if (rst) begin
      mode_r  = MODE_RESET;
      floor_r = FLOOR_RESET;
      sweep_r = 2'd0;
      expected_resid_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MODE) begin
          mode_r  = pwdata[2:0];
          sweep_r = 2'd0;
        end else begin
          floor_r = pwdata[15:0];
        end
      end
      if (point.valid && point.ready) begin
        if (point.new_evaluation && sweep_r < SWEEP_MAX) sweep_r = sweep_r + 2'd1;
        expected_resid_q.push_back(predict_residual(point.meas_real, point.meas_imag,
                                                    point.fit_real, point.fit_imag));
      end
      if (resid.valid && resid.ready) begin
        got = '{resid.resid_real, resid.resid_imag, resid.saturated};
        if (expected_resid_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected residual beat: re=%h im=%h sat=%b", got.re, got.im, got.sat);
        end else begin
          want = expected_resid_q.pop_front();
          if (got.re !== want.re || got.im !== want.im || got.sat !== want.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("residual mismatch: expected re=%h im=%h sat=%b, got re=%h im=%h sat=%b",
                       want.re, want.im, want.sat, got.re, got.im, got.sat);
          end
        end
      end
    end
    pending <= expected_resid_q.size();
  end

endmodule

@@ bench/tb_weighted_impedance_residual_unit.sv @@
// Testbench top: clock, reset, register writes, point stimulus, backpressure and verdict.
`timescale 1ns / 1ps

module tb_weighted_impedance_residual_unit;
  import wir_pkg::*;

  localparam logic [2:0]  MODE_SPARE  = 3'd7;
  localparam logic [15:0] FLOOR_MAX   = 16'hFFFF;
  localparam logic [31:0] Q_MIN       = 32'h8000_0000;
  localparam logic [31:0] Q_MAX       = 32'h7FFF_FFFF;
  localparam int          HOLD_CYCLES = 500;
  localparam int          SEG_ITEMS   = 84;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches;
  int          pending;
  int          src_idle_pct;
  int          sink_idle_pct;
  int          hold_requests;

  wir_point_if point_ch();
  wir_resid_if resid_ch();

  weighted_impedance_residual_unit uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .point   (point_ch),
    .resid   (resid_ch)
  );

  wir_residual_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .point      (point_ch),
    .resid      (resid_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // Receiver: random ready, plus a long hold-off on request
  initial begin
    int holds_done;
    holds_done     = 0;
    resid_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        resid_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      resid_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Offer one point beat and wait for it to be taken
  task automatic send_point(input logic [31:0] mr, input logic [31:0] mi,
                            input logic [31:0] fr, input logic [31:0] fi,
                            input logic ne);
    int gap;
    gap = 0;
    if ($urandom_range(99) < src_idle_pct / 4) gap = $urandom_range(1, 80);
    while (gap > 0 || $urandom_range(99) < src_idle_pct) begin
      point_ch.valid <= 1'b0;
      @(posedge clk);
      if (gap > 0) gap--;
    end
    point_ch.valid          <= 1'b1;
    point_ch.meas_real      <= mr;
    point_ch.meas_imag      <= mi;
    point_ch.fit_real       <= fr;
    point_ch.fit_imag       <= fi;
    point_ch.new_evaluation <= ne;
    do @(posedge clk); while (!point_ch.ready);
  endtask

  // Stop offering and wait until every expected residual has come back
  task automatic drain_points();
    point_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  // APB write while the block is idle
  task automatic write_reg(input logic idx, input logic [31:0] value);
    drain_points();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Q16.16 value: extremes, zero, tiny, moderate and full-range
  function automatic logic [31:0] pick_q16();
    logic [31:0] v;
    case ($urandom_range(9))
      0:       v = 32'd0;
      1:       v = Q_MIN;
      2:       v = Q_MAX;
      3, 4:    v = $urandom();
      5, 6:    v = $urandom_range(32'h0010_0000) - 32'h0008_0000;
      7:       v = $urandom_range(510) - 255;
      default: begin
        v = $urandom() >> $urandom_range(24);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // Random sweeps: short point lists, marked mostly on their first point
  task automatic send_sweeps(input int count);
    int          left, len;
    logic [31:0] mr, mi, fr, fi;
    logic        ne;
    left = count;
    while (left > 0) begin
      len = $urandom_range(1, 12);
      for (int k = 0; k < len && left > 0; k++) begin
        ne = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
        mr = pick_q16();
        mi = pick_q16();
        fr = $urandom_range(1) ? mr + ($urandom_range(2046) - 1023) : pick_q16();
        fi = $urandom_range(1) ? mi + ($urandom_range(2046) - 1023) : pick_q16();
        send_point(mr, mi, fr, fi, ne);
        left--;
      end
    end
  endtask

  // Main stimulus
  initial begin
    logic [15:0] floor_v;
    rst                     = 1'b1;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    point_ch.valid          = 1'b0;
    point_ch.meas_real      = '0;
    point_ch.meas_imag      = '0;
    point_ch.fit_real       = '0;
    point_ch.fit_imag       = '0;
    point_ch.new_evaluation = 1'b0;
    hold_requests           = 0;
    src_idle_pct            = 24;
    sink_idle_pct           = 62;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset config, auto modulus: before a mark, first sweep, later sweeps
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 1'b0);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 1'b1);
    send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000, 32'h0000_0000, 1'b0);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 1'b1);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 1'b1);

    // Unity weight with largest differences
    write_reg(REG_MODE, 32'(MODE_UNITY));
    send_point(Q_MIN, Q_MIN, Q_MAX, Q_MAX, 1'b0);
    send_point(Q_MAX, Q_MAX, Q_MIN, Q_MIN, 1'b0);
    send_point(32'd5, 32'd5, 32'd5, 32'd5, 1'b1);

    // Measured modulus: zero square, zero residual, divider clip, huge square
    write_reg(REG_MODE, 32'(MODE_MOD_MEAS));
    send_point(32'd0, 32'd0, Q_MAX, Q_MIN, 1'b0);
    send_point(32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
    send_point(32'd1, 32'd0, Q_MIN, Q_MAX, 1'b0);
    send_point(Q_MIN, Q_MIN, Q_MAX, Q_MAX, 1'b0);

    write_reg(REG_MODE, 32'(MODE_PROP_MEAS));
    send_point(32'd0, Q_MAX, Q_MAX, 32'd0, 1'b0);
    send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0000_0000, 1'b0);

    write_reg(REG_MODE, 32'(MODE_MOD_FIT));
    send_point(Q_MAX, Q_MAX, Q_MIN, Q_MIN, 1'b0);
    send_point(32'd7, -32'd9, 32'd0, 32'd0, 1'b0);

    write_reg(REG_MODE, 32'(MODE_PROP_FIT));
    send_point(32'h0000_1000, 32'h1234_5678, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0);

    // Auto proportional: mode write restarts sweep counting
    write_reg(REG_MODE, 32'(MODE_PROP_AUTO));
    send_point(32'h0002_0000, 32'h0000_4000, 32'h0004_0000, 32'hFFFE_0000, 1'b0);
    send_point(32'h0002_0000, 32'h0000_4000, 32'h0004_0000, 32'hFFFE_0000, 1'b1);
    send_point(32'h0002_0000, 32'h0000_4000, 32'h0004_0000, 32'hFFFE_0000, 1'b1);

    // Unused mode code behaves as unity
    write_reg(REG_MODE, 32'(MODE_SPARE));
    send_point(Q_MIN, 32'd0, Q_MAX, 32'd0, 1'b0);

    // Floor extremes: just above, below, and a zero floor with a zero square
    write_reg(REG_MODE, 32'(MODE_MOD_MEAS));
    write_reg(REG_FLOOR, 32'(FLOOR_MAX));
    send_point(32'h0000_0100, 32'd0, 32'h0100_0000, 32'd0, 1'b0);
    write_reg(REG_MODE, 32'(MODE_PROP_MEAS));
    send_point(32'h0000_00FF, 32'hFFFF_FF01, 32'h0000_1000, 32'd0, 1'b0);
    write_reg(REG_FLOOR, 32'd0);
    send_point(32'd0, 32'h0000_0100, 32'h0000_0010, 32'h0000_0100, 1'b0);

    // Random part: three idle patterns, each over every mode and several floors
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin src_idle_pct = 24; sink_idle_pct = 62; end
        1:       begin src_idle_pct = 62; sink_idle_pct = 24; end
        default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
      endcase
      for (int seg = 0; seg < 8; seg++) begin
        case (seg % 4)
          0:       floor_v = 16'd0;
          1:       floor_v = FLOOR_MAX;
          2:       floor_v = 16'd1;
          default: floor_v = $urandom_range(65535);
        endcase
        write_reg(REG_MODE, 32'((seg * 3 + phase) % 8));
        write_reg(REG_FLOOR, {16'd0, floor_v});
        if (seg == 1) hold_requests++;
        if (seg == 3) begin
          send_sweeps(SEG_ITEMS / 2);
          drain_points();
          send_sweeps(SEG_ITEMS - SEG_ITEMS / 2);
        end else begin
          send_sweeps(SEG_ITEMS);
        end
      end
    end

    // Wind down and report
    drain_points();
    repeat (80) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
